// ===== design/adsm_pkg.sv =====
// Shared types and helpers for the aim dwell state machine.
// No dependencies; used by adsm_ratio and aim_dwell_state_machine.
package adsm_pkg;

  // Output codes for aim_state
  localparam logic [1:0] CODE_NOT_AIMING = 2'd0;
  localparam logic [1:0] CODE_AIMING     = 2'd1;
  localparam logic [1:0] CODE_AIMED      = 2'd2;
  localparam logic [1:0] CODE_RESETTING  = 2'd3;

  // Register indexes on the config write port
  localparam logic [2:0] CFG_X_LIMIT   = 3'd0;
  localparam logic [2:0] CFG_Y_LIMIT   = 3'd1;
  localparam logic [2:0] CFG_DWELL_MS  = 3'd2;
  localparam logic [2:0] CFG_HOLD_MS   = 3'd3;
  localparam logic [2:0] CFG_RESET_MS  = 3'd4;
  localparam logic [2:0] CFG_MAX_RATIO = 3'd5;
  localparam logic [2:0] CFG_MIN_RATIO = 3'd6;
  localparam logic [2:0] CFG_DOT_MODE  = 3'd7;

  typedef enum logic [3:0] {
    ST_NOT_AIMING = 4'b0001,
    ST_AIMING     = 4'b0010,
    ST_AIMED      = 4'b0100,
    ST_RESETTING  = 4'b1000
  } aim_state_t;

  // Ratio test results handed from the ratio stage to the state machine
  typedef struct packed {
    logic need_back;
    logic too_small;
  } ratio_flags_t;

  function automatic logic [1:0] aim_code(input aim_state_t st);
    logic [1:0] code;
    case (st)
      ST_NOT_AIMING: code = CODE_NOT_AIMING;
      ST_AIMING:     code = CODE_AIMING;
      ST_AIMED:      code = CODE_AIMED;
      ST_RESETTING:  code = CODE_RESETTING;
      default:       code = CODE_NOT_AIMING;
    endcase
    return code;
  endfunction

endpackage

// ===== design/adsm_ratio.sv =====
// Box-to-image area ratio stage: registers the three products and compares.
// Depends on adsm_pkg (ratio_flags_t).
module adsm_ratio (
  input  logic                  clk,
  input  logic                  en,
  input  logic [11:0]           box_width,
  input  logic [11:0]           box_height,
  input  logic [24:0]           img_pixels,
  input  logic [15:0]           max_ratio,
  input  logic [15:0]           min_ratio,
  output adsm_pkg::ratio_flags_t flags
);

  logic [23:0] area;
  logic [40:0] max_prod;
  logic [40:0] min_prod;
  logic [40:0] scaled;

  always_ff @(posedge clk) begin
    if (en) begin
      area     <= 24'(box_width) * 24'(box_height);
      max_prod <= 41'(max_ratio) * 41'(img_pixels);
      min_prod <= 41'(min_ratio) * 41'(img_pixels);
    end
  end

  // area as Q24.16 against Q0.16 ratio * image area
  assign scaled          = {1'b0, area, 16'h0000};
  assign flags.need_back = scaled > max_prod;
  assign flags.too_small = scaled < min_prod;

endmodule

// ===== design/aim_dwell_state_machine.sv =====
// Aim dwell state machine top level: stream ports, config registers, FSM.
// Depends on adsm_pkg and adsm_ratio.

// One request per detection goes through three register stages: the input
// register, the product stage (box area and the two ratio limits times the
// image area, plus the in-range test) and the result register, where the aim
// state machine updates. A new request is taken every cycle when the output
// side keeps up, and a stalled output backs up through all three stages. The
// state and the three start times live only in the last stage, so each request
// sees the state left by the one before it. Configuration writes take effect
// at once and should be made while no request is in flight.
module aim_dwell_state_machine (
  input  logic         clk,
  input  logic         rst,
  // config write port
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  // detection requests
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [12:0] diff_x, [25:13] diff_y, [37:26] box_width, [49:38] box_height,
  // [74:50] img_pixels, [106:75] now_ms, [111:107] zero
  input  logic [111:0] s_axis_tdata,
  // [0] red_dot
  input  logic         s_axis_tuser,
  // results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] aim_state, [2] need_back, [3] timing, [7:4] zero
  output logic [7:0]   m_axis_tdata
);

  // ---------------- configuration registers ----------------
  logic [11:0] x_limit;
  logic [11:0] y_limit;
  logic [15:0] dwell_ms;
  logic [15:0] hold_ms;
  logic [15:0] reset_ms;
  logic [15:0] max_ratio;
  logic [15:0] min_ratio;
  logic        dot_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit   <= 12'd10;
      y_limit   <= 12'd10;
      dwell_ms  <= 16'd500;
      hold_ms   <= 16'd1000;
      reset_ms  <= 16'd1000;
      max_ratio <= 16'd19661;
      min_ratio <= 16'd66;
      dot_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        adsm_pkg::CFG_X_LIMIT:   x_limit   <= cfg_data[11:0];
        adsm_pkg::CFG_Y_LIMIT:   y_limit   <= cfg_data[11:0];
        adsm_pkg::CFG_DWELL_MS:  dwell_ms  <= cfg_data;
        adsm_pkg::CFG_HOLD_MS:   hold_ms   <= cfg_data;
        adsm_pkg::CFG_RESET_MS:  reset_ms  <= cfg_data;
        adsm_pkg::CFG_MAX_RATIO: max_ratio <= cfg_data;
        adsm_pkg::CFG_MIN_RATIO: min_ratio <= cfg_data;
        adsm_pkg::CFG_DOT_MODE:  dot_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  // Each stage moves when the one after it is empty or moving.
  logic s1_valid;
  logic s2_valid;
  logic out_valid;
  logic out_ready;
  logic s2_ready;

  assign out_ready     = !out_valid || m_axis_tready;
  assign s2_ready      = !s2_valid || out_ready;
  assign s_axis_tready = !s1_valid || s2_ready;
  assign m_axis_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) s1_valid  <= s_axis_tvalid;
      if (s2_ready)      s2_valid  <= s1_valid;
      if (out_ready)     out_valid <= s2_valid;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic signed [12:0] s1_diff_x;
  logic signed [12:0] s1_diff_y;
  logic [11:0]        s1_box_width;
  logic [11:0]        s1_box_height;
  logic [24:0]        s1_img_pixels;
  logic               s1_red_dot;
  logic [31:0]        s1_now_ms;

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_diff_x     <= s_axis_tdata[12:0];
      s1_diff_y     <= s_axis_tdata[25:13];
      s1_box_width  <= s_axis_tdata[37:26];
      s1_box_height <= s_axis_tdata[49:38];
      s1_img_pixels <= s_axis_tdata[74:50];
      s1_now_ms     <= s_axis_tdata[106:75];
      s1_red_dot    <= s_axis_tuser;
    end
  end

  // Magnitudes reach 4096 for the most negative offset, so keep 13 bits.
  logic [12:0] abs_x;
  logic [12:0] abs_y;
  logic        s1_in_range;

  assign abs_x = s1_diff_x[12] ? 13'(-s1_diff_x) : 13'(s1_diff_x);
  assign abs_y = s1_diff_y[12] ? 13'(-s1_diff_y) : 13'(s1_diff_y);
  assign s1_in_range = dot_mode ? s1_red_dot
                     : (abs_x <= {1'b0, x_limit}) && (abs_y <= {1'b0, y_limit});

  // ---------------- stage 2: products and in-range ----------------
  logic                   s2_en;
  logic                   s2_in_range;
  logic [31:0]            s2_now_ms;
  adsm_pkg::ratio_flags_t s2_flags;

  assign s2_en = s2_ready && s1_valid;

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_in_range <= s1_in_range;
      s2_now_ms   <= s1_now_ms;
    end
  end

  adsm_ratio u_ratio (
    .clk        (clk),
    .en         (s2_en),
    .box_width  (s1_box_width),
    .box_height (s1_box_height),
    .img_pixels (s1_img_pixels),
    .max_ratio  (max_ratio),
    .min_ratio  (min_ratio),
    .flags      (s2_flags)
  );

  // ---------------- stage 3: state machine and result ----------------
  adsm_pkg::aim_state_t state;
  adsm_pkg::aim_state_t state_next;
  logic                 timing_flag;
  logic                 timing_flag_next;
  logic [31:0]          aim_start;
  logic [31:0]          aimed_start;
  logic [31:0]          reset_start;
  logic                 load_aim;
  logic                 load_aimed;
  logic                 load_reset;
  logic [31:0]          dwell_age;
  logic [31:0]          hold_age;
  logic [31:0]          reset_age;
  logic                 step;

  // Elapsed times wrap modulo 2^32 with the timestamp.
  assign dwell_age = s2_now_ms - aim_start;
  assign hold_age  = s2_now_ms - aimed_start;
  assign reset_age = s2_now_ms - reset_start;
  assign step      = out_ready && s2_valid;

  always_comb begin
    state_next       = state;
    timing_flag_next = timing_flag;
    load_aim         = 1'b0;
    load_aimed       = 1'b0;
    load_reset       = 1'b0;
    if (s2_flags.too_small) begin
      state_next       = adsm_pkg::ST_NOT_AIMING;
      timing_flag_next = 1'b0;
    end else begin
      case (state)
        adsm_pkg::ST_NOT_AIMING: begin
          if (s2_in_range) begin
            state_next       = adsm_pkg::ST_AIMING;
            timing_flag_next = 1'b1;
            load_aim         = 1'b1;
          end
        end
        adsm_pkg::ST_AIMING: begin
          if (!s2_in_range) begin
            state_next       = adsm_pkg::ST_NOT_AIMING;
            timing_flag_next = 1'b0;
          end else if (dwell_age >= 32'(dwell_ms)) begin
            state_next = adsm_pkg::ST_AIMED;
            load_aimed = 1'b1;
          end
        end
        adsm_pkg::ST_AIMED: begin
          // hold expiry wins over losing the target
          if (hold_age >= 32'(hold_ms)) begin
            state_next = adsm_pkg::ST_RESETTING;
            load_reset = 1'b1;
          end else if (!s2_in_range) begin
            state_next       = adsm_pkg::ST_NOT_AIMING;
            timing_flag_next = 1'b0;
          end
        end
        adsm_pkg::ST_RESETTING: begin
          if (reset_age >= 32'(reset_ms)) begin
            state_next       = adsm_pkg::ST_NOT_AIMING;
            timing_flag_next = 1'b0;
          end
        end
        default: begin
          state_next       = adsm_pkg::ST_NOT_AIMING;
          timing_flag_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= adsm_pkg::ST_NOT_AIMING;
      timing_flag <= 1'b0;
    end else if (step) begin
      state       <= state_next;
      timing_flag <= timing_flag_next;
    end
  end

  // start stamps and result payload carry no reset
  always_ff @(posedge clk) begin
    if (step) begin
      if (load_aim)   aim_start   <= s2_now_ms;
      if (load_aimed) aimed_start <= s2_now_ms;
      if (load_reset) reset_start <= s2_now_ms;
      m_axis_tdata <= {4'b0000, timing_flag_next, s2_flags.need_back,
                       adsm_pkg::aim_code(state_next)};
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for aim_dwell_state_machine: directed table, then random phases
// under several register settings. Depends on adsm_pkg and the design sources only.
module testbench;

  // Detection request as packed on s_axis_tdata, diff_x in the lowest bits
  typedef struct packed {
    logic [31:0]        now_ms;
    logic [24:0]        img_pixels;
    logic [11:0]        box_height;
    logic [11:0]        box_width;
    logic signed [12:0] diff_y;
    logic signed [12:0] diff_x;
  } detection_t;

  // Result as packed on m_axis_tdata[3:0]
  typedef struct packed {
    logic       timing;
    logic       need_back;
    logic [1:0] aim_state;
  } aim_result_t;

  // Directed row: request plus, where obvious, the hand-written result
  typedef struct packed {
    detection_t  det;
    logic        dot;
    logic        typed;
    aim_result_t res;
  } plan_row_t;

  typedef struct packed {
    logic        typed;
    aim_result_t res;
  } preset_t;

  localparam int          NUM_PHASES      = 8;
  localparam int          ITEMS_PER_PHASE = 166;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam logic [24:0] IMG_64K         = 25'd65536;  // ratio limit == area limit

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;

  // Register shadows, reset values
  logic [11:0] x_limit_q   = 12'd10;
  logic [11:0] y_limit_q   = 12'd10;
  logic [15:0] dwell_q     = 16'd500;
  logic [15:0] hold_q      = 16'd1000;
  logic [15:0] reset_q     = 16'd1000;
  logic [15:0] max_ratio_q = 16'd19661;
  logic [15:0] min_ratio_q = 16'd66;
  logic        dot_mode_q  = 1'b0;

  // Aim state shadow; start times are always written before use
  logic [1:0]  aim_code_q    = adsm_pkg::CODE_NOT_AIMING;
  logic        timing_q      = 1'b0;
  logic [31:0] aim_start_q   = '0;
  logic [31:0] aimed_start_q = '0;
  logic [31:0] reset_start_q = '0;

  aim_result_t pending_q [$];   // results owed by the block, oldest first
  preset_t     preset_q [$];    // one per directed request, in send order
  int unsigned fail_count   = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count  = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic [31:0] stamp_ms;        // running time line for well-formed requests

  aim_dwell_state_machine u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver: stall at the phase's rate, new decision every cycle
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Steps the aim state shadow for one accepted request, returns the result it owes.
  function automatic aim_result_t predict_aim(detection_t d, logic dot);
    logic [12:0] mag_x, mag_y;
    logic [63:0] scaled;
    logic        need_back, too_small, hit;
    aim_result_t r;
    mag_x = d.diff_x[12] ? 13'(-d.diff_x) : d.diff_x;   // -4096 gives 4096
    mag_y = d.diff_y[12] ? 13'(-d.diff_y) : d.diff_y;
    // area / image vs Q0.16 limit, done without division
    scaled    = (64'(d.box_width) * 64'(d.box_height)) << 16;
    need_back = scaled > 64'(max_ratio_q) * 64'(d.img_pixels);
    too_small = scaled < 64'(min_ratio_q) * 64'(d.img_pixels);
    hit = dot_mode_q ? dot : (mag_x <= 13'(x_limit_q) && mag_y <= 13'(y_limit_q));
    if (too_small) begin
      aim_code_q = adsm_pkg::CODE_NOT_AIMING;
      timing_q   = 1'b0;
    end else begin
      case (aim_code_q)
        adsm_pkg::CODE_NOT_AIMING: begin
          if (hit) begin
            aim_code_q  = adsm_pkg::CODE_AIMING;
            timing_q    = 1'b1;
            aim_start_q = d.now_ms;
          end
        end
        adsm_pkg::CODE_AIMING: begin
          if (!hit) begin
            aim_code_q = adsm_pkg::CODE_NOT_AIMING;
            timing_q   = 1'b0;
          end else if (32'(d.now_ms - aim_start_q) >= 32'(dwell_q)) begin
            aim_code_q    = adsm_pkg::CODE_AIMED;
            aimed_start_q = d.now_ms;
          end
        end
        adsm_pkg::CODE_AIMED: begin
          // hold expiry wins over leaving range
          if (32'(d.now_ms - aimed_start_q) >= 32'(hold_q)) begin
            aim_code_q    = adsm_pkg::CODE_RESETTING;
            reset_start_q = d.now_ms;
          end else if (!hit) begin
            aim_code_q = adsm_pkg::CODE_NOT_AIMING;
            timing_q   = 1'b0;
          end
        end
        default: begin
          // resetting ignores range entirely
          if (32'(d.now_ms - reset_start_q) >= 32'(reset_q)) begin
            aim_code_q = adsm_pkg::CODE_NOT_AIMING;
            timing_q   = 1'b0;
          end
        end
      endcase
    end
    r.aim_state = aim_code_q;
    r.need_back = need_back;
    r.timing    = timing_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("result %0d: %s", result_count, what);
  endtask

  // Scoreboard: predict on request accept, compare on result accept
  aim_result_t want, got;
  preset_t     preset;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_aim(detection_t'(s_axis_tdata[106:0]), s_axis_tuser);
        if (preset_q.size() != 0) begin
          preset = preset_q.pop_front();
          if (preset.typed) want = preset.res;
        end
        pending_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = aim_result_t'(m_axis_tdata[3:0]);
        if (pending_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result 0x%02h", m_axis_tdata));
        end else begin
          want = pending_q.pop_front();
          if (got.aim_state !== want.aim_state)
            report_mismatch($sformatf("aim_state %0d, expected %0d",
                                      got.aim_state, want.aim_state));
          if (got.need_back !== want.need_back)
            report_mismatch($sformatf("need_back %0b, expected %0b",
                                      got.need_back, want.need_back));
          if (got.timing !== want.timing)
            report_mismatch($sformatf("timing %0b, expected %0b",
                                      got.timing, want.timing));
        end
        result_count++;
      end
    end
  end

  // Offset whose magnitude is inside or outside the limit; 4096 only as -4096
  function automatic logic [12:0] pick_offset(logic [11:0] limit, logic in_lim);
    int unsigned mag;
    mag = in_lim ? $urandom_range(0, 32'(limit))
                 : $urandom_range(32'(limit) + 32'd1, 4096);
    if (mag == 4096) return 13'h1000;
    return $urandom_range(0, 1) ? 13'(-mag) : 13'(mag);
  endfunction

  // Random request. Mostly well-formed: time moves forward along stamp_ms, the box
  // ratio lies between the limits and the target is mostly in range, so the state
  // machine gets through all four states. The rest is noise, tiny boxes, time jumps
  // (wrap included) and hits placed right at the next timer expiry.
  task automatic make_detection(output detection_t d, output logic dot);
    int unsigned pick, span, lo, hi, lo_w, hi_w, bw, bh, axis;
    logic [63:0] img, area;
    logic [31:0] target;
    logic        hit;
    pick = $urandom_range(99);
    span = (int'(dwell_q) + int'(hold_q) + int'(reset_q)) / 6 + 4;
    d.diff_x = 13'($urandom);
    d.diff_y = 13'($urandom);
    dot      = 1'($urandom);
    if (pick < 10) begin
      // noise: full width on every field, off the time line
      d.box_width  = 12'($urandom);
      d.box_height = 12'($urandom);
      d.img_pixels = 25'($urandom);
      d.now_ms     = $urandom;
    end else begin
      if (pick < 14) begin
        stamp_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3000);
      end else if (pick >= 20 && pick < 35) begin
        case (aim_code_q)
          adsm_pkg::CODE_AIMING:    target = aim_start_q + 32'(dwell_q);
          adsm_pkg::CODE_AIMED:     target = aimed_start_q + 32'(hold_q);
          adsm_pkg::CODE_RESETTING: target = reset_start_q + 32'(reset_q);
          default:                  target = stamp_ms + span;
        endcase
        stamp_ms = target - $urandom_range(0, 1);   // one short of expiry, or on it
      end else begin
        stamp_ms = stamp_ms + $urandom_range(0, span);
      end
      d.now_ms = stamp_ms;
      lo = 32'(min_ratio_q);
      hi = 32'(max_ratio_q);
      if (lo > hi) begin
        lo = 32'(max_ratio_q);
        hi = 32'(min_ratio_q);
      end
      img  = 64'($urandom_range(1, 1 << $urandom_range(6, 24)));
      area = (img * 64'($urandom_range(lo, hi)) + 64'd65535) >> 16;
      if (area > 64'(4095 * 4095)) area = 64'(4095 * 4095);
      if (pick >= 14 && pick < 20) begin
        // tiny box on a large image
        bw  = $urandom_range(0, 3);
        bh  = $urandom_range(0, 3);
        img = 64'($urandom_range(1 << 20, 1 << 24));
      end else if (area == '0) begin
        bw = $urandom_range(0, 4095);
        bh = 0;
      end else begin
        lo_w = 32'((area + 64'd4094) / 64'd4095);
        hi_w = (area < 64'd4095) ? 32'(area) : 32'd4095;
        bw   = $urandom_range(lo_w, hi_w);
        bh   = 32'((area + 64'(bw) - 64'd1) / 64'(bw));
        if (bh > 4095) bh = 4095;
      end
      d.box_width  = 12'(bw);
      d.box_height = 12'(bh);
      d.img_pixels = 25'(img);
      hit = $urandom_range(99) < 85;
      if (dot_mode_q) begin
        dot = hit;
      end else begin
        // 0: x out, 1: y out, 2: both out, 3: both in
        axis = hit ? 3 : $urandom_range(0, 2);
        d.diff_x = pick_offset(x_limit_q, axis == 1 || axis == 3);
        d.diff_y = pick_offset(y_limit_q, axis == 0 || axis == 3);
      end
    end
  endtask

  // Present one request from a falling edge, hold it until accepted.
  task automatic send_detection(input detection_t d, input logic dot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, d};
    s_axis_tuser  <= dot;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending until every owed result is back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_q.size() != 0);
  endtask

  function automatic plan_row_t mk(int dx, int dy, int bw, int bh, logic [24:0] img,
                                   logic dot, logic [31:0] t_ms, logic typed,
                                   logic [1:0] st, logic nb, logic tm);
    plan_row_t r;
    r.det.diff_x     = 13'(dx);
    r.det.diff_y     = 13'(dy);
    r.det.box_width  = 12'(bw);
    r.det.box_height = 12'(bh);
    r.det.img_pixels = img;
    r.det.now_ms     = t_ms;
    r.dot            = dot;
    r.typed          = typed;
    r.res.aim_state  = st;
    r.res.need_back  = nb;
    r.res.timing     = tm;
    return r;
  endfunction

  // Idle profile per phase: none, sender, receiver, both
  int unsigned idle_send  [4] = '{0, 73, 0, 19};
  int unsigned idle_stall [4] = '{0, 0, 73, 19};

  plan_row_t   plan [$];
  detection_t  det;
  logic        dot;
  logic [15:0] vals [8];

  initial begin
    stamp_ms = $urandom;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset settings. Image area of 64K makes the ratio limits
    // plain area limits: need back above 19661, too small below 66.
    // dwell 500, hold 1000, reset 1000, offsets in range up to 10.
    plan.push_back(mk(0, 0, 100, 100, IMG_64K, 0, 1000, 1, adsm_pkg::CODE_AIMING, 0, 1));
    plan.push_back(mk(0, 0, 100, 100, IMG_64K, 0, 1499, 1, adsm_pkg::CODE_AIMING, 0, 1));
    plan.push_back(mk(0, 0, 100, 100, IMG_64K, 0, 1500, 1, adsm_pkg::CODE_AIMED, 0, 1));
    plan.push_back(mk(11, 0, 100, 100, IMG_64K, 0, 1600, 1,
                      adsm_pkg::CODE_NOT_AIMING, 0, 0));
    plan.push_back(mk(-10, 10, 100, 100, IMG_64K, 0, 2000, 1, adsm_pkg::CODE_AIMING, 0, 1));
    plan.push_back(mk(0, 0, 100, 100, IMG_64K, 0, 2500, 1, adsm_pkg::CODE_AIMED, 0, 1));
    // hold expiry beats out-of-range
    plan.push_back(mk(4095, 4095, 100, 100, IMG_64K, 0, 3500, 1,
                      adsm_pkg::CODE_RESETTING, 0, 1));
    plan.push_back(mk(0, 0, 100, 100, IMG_64K, 0, 4499, 1,
                      adsm_pkg::CODE_RESETTING, 0, 1));
    plan.push_back(mk(0, 0, 100, 100, IMG_64K, 0, 4500, 1,
                      adsm_pkg::CODE_NOT_AIMING, 0, 0));
    // too-small edge: 65 forced off, 66 allowed
    plan.push_back(mk(0, 0, 65, 1, IMG_64K, 0, 4600, 1, adsm_pkg::CODE_NOT_AIMING, 0, 0));
    plan.push_back(mk(0, 0, 66, 1, IMG_64K, 0, 4700, 1, adsm_pkg::CODE_AIMING, 0, 1));
    plan.push_back(mk(0, 0, 1, 0, IMG_64K, 0, 4800, 1, adsm_pkg::CODE_NOT_AIMING, 0, 0));
    // full box, need back; dot flag ignored in offset mode
    plan.push_back(mk(0, 0, 4095, 4095, IMG_64K, 1, 5000, 1, adsm_pkg::CODE_AIMING, 1, 1));
    plan.push_back(mk(0, 0, 20, 983, IMG_64K, 0, 5100, 1, adsm_pkg::CODE_AIMING, 0, 1));
    plan.push_back(mk(0, 0, 113, 174, IMG_64K, 0, 5200, 1, adsm_pkg::CODE_AIMING, 1, 1));
    plan.push_back(mk(-4096, 0, 100, 100, IMG_64K, 0, 5300, 1,
                      adsm_pkg::CODE_NOT_AIMING, 0, 0));
    // zero image area: any non-zero box area raises need back, never too small
    plan.push_back(mk(0, 0, 1, 1, 25'd0, 0, 5400, 1, adsm_pkg::CODE_AIMING, 1, 1));
    plan.push_back(mk(0, 0, 0, 0, 25'd0, 0, 5400, 1, adsm_pkg::CODE_AIMING, 0, 1));
    plan.push_back(mk(0, 0, 4095, 4095, 25'h1FF_FFFF, 0, 5500, 0,
                      adsm_pkg::CODE_AIMING, 0, 0));
    // dwell across the 32-bit time wrap
    plan.push_back(mk(11, 0, 100, 100, IMG_64K, 0, 32'hFFFF_FF00, 1,
                      adsm_pkg::CODE_NOT_AIMING, 0, 0));
    plan.push_back(mk(0, 0, 100, 100, IMG_64K, 0, 32'hFFFF_FF00, 1,
                      adsm_pkg::CODE_AIMING, 0, 1));
    plan.push_back(mk(0, 0, 100, 100, IMG_64K, 0, 32'h0000_00F3, 1,
                      adsm_pkg::CODE_AIMING, 0, 1));
    plan.push_back(mk(0, 0, 100, 100, IMG_64K, 0, 32'h0000_00F4, 1,
                      adsm_pkg::CODE_AIMED, 0, 1));
    plan.push_back(mk(0, -4096, 100, 100, IMG_64K, 0, 32'h0000_0100, 1,
                      adsm_pkg::CODE_NOT_AIMING, 0, 0));
    foreach (plan[i]) begin
      preset_q.push_back('{plan[i].typed, plan[i].res});
      send_detection(plan[i].det, plan[i].dot);
    end

    // Random phases, each under its own register setting and idle profile.
    // Phase 1 is all zeros, phase 2 all ones; the rest random, with junk above
    // the narrow registers' width.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      foreach (vals[i]) vals[i] = 16'($urandom);
      if (p == 1) begin
        foreach (vals[i]) vals[i] = 16'h0000;
      end else if (p == 2) begin
        foreach (vals[i]) vals[i] = 16'hFFFF;
      end else begin
        vals[adsm_pkg::CFG_X_LIMIT][11:0] = $urandom_range(0, 1)
                                            ? 12'($urandom_range(0, 40))
                                            : 12'($urandom);
        vals[adsm_pkg::CFG_Y_LIMIT][11:0] = $urandom_range(0, 1)
                                            ? 12'($urandom_range(0, 40))
                                            : 12'($urandom);
        vals[adsm_pkg::CFG_DWELL_MS] = 16'($urandom_range(0, 2500));
        vals[adsm_pkg::CFG_HOLD_MS]  = 16'($urandom_range(0, 2500));
        vals[adsm_pkg::CFG_RESET_MS] = 16'($urandom_range(0, 2500));
        if (p != 6) begin   // phase 6 keeps fully random ratios, min above max possible
          vals[adsm_pkg::CFG_MIN_RATIO] = 16'($urandom_range(0, 3000));
          vals[adsm_pkg::CFG_MAX_RATIO] =
            16'($urandom_range(vals[adsm_pkg::CFG_MIN_RATIO], 65535));
        end
        vals[adsm_pkg::CFG_DOT_MODE][0] = 1'(p % 2);
      end
      for (int i = 0; i < 8; i++) begin
        cfg_we    <= 1'b1;
        cfg_index <= 3'(i);
        cfg_data  <= vals[i];
        case (3'(i))
          adsm_pkg::CFG_X_LIMIT:   x_limit_q   = vals[i][11:0];
          adsm_pkg::CFG_Y_LIMIT:   y_limit_q   = vals[i][11:0];
          adsm_pkg::CFG_DWELL_MS:  dwell_q     = vals[i];
          adsm_pkg::CFG_HOLD_MS:   hold_q      = vals[i];
          adsm_pkg::CFG_RESET_MS:  reset_q     = vals[i];
          adsm_pkg::CFG_MAX_RATIO: max_ratio_q = vals[i];
          adsm_pkg::CFG_MIN_RATIO: min_ratio_q = vals[i];
          adsm_pkg::CFG_DOT_MODE:  dot_mode_q  = vals[i][0];
          default: ;
        endcase
        @(negedge clk);
      end
      cfg_we <= 1'b0;
      send_idle_pct  = idle_send[p % 4];
      recv_stall_pct = idle_stall[p % 4];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) == 0) settle();   // full drain mid-phase
        make_detection(det, dot);
        send_detection(det, dot);
      end
    end

    settle();
    repeat (12) @(negedge clk);   // catch any stray result after the last one
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
